[sv/tmpm_pkg.sv]
// ============================================================================
// tmpm_pkg - shared types and constants of the trimmed-mean power meter
// Field widths, register indexes and reset values, and the item, window and
// configuration structs that pass between the modules.
// ============================================================================
package tmpm_pkg;

    // Field and datapath widths
    localparam int ADC_W   = 12;
    localparam int SUM_W   = 18;
    localparam int VAL_W   = 16;
    localparam int SCALE_W = 24;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;
    localparam int CNT_W   = 6;
    localparam int PROD_W  = ADC_W + SCALE_W;
    localparam int Q_FRAC  = 16;
    localparam int CH_N    = 3;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADC_W-1:0] ADC_MAX = '1;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_VOLT_SCALE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_VOLT_OFFSET   = 2'd1;
    localparam logic [IDX_W-1:0] REG_CURR_SCALE    = 2'd2;
    localparam logic [IDX_W-1:0] REG_CURR_DEADBAND = 2'd3;

    // Register reset values
    localparam logic [SCALE_W-1:0]       VOLT_SCALE_RST    = 24'd5281;
    localparam logic signed [BYTE_W-1:0] VOLT_OFFSET_RST   = 8'sd7;
    localparam logic [SCALE_W-1:0]       CURR_SCALE_RST    = 24'd21125;
    localparam logic [BYTE_W-1:0]        CURR_DEADBAND_RST = 8'd7;

    typedef struct packed {
        logic [ADC_W-1:0] volt_sample;
        logic [ADC_W-1:0] curr_sample;
        logic [ADC_W-1:0] ref_sample;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] volt_value;
        logic [VAL_W-1:0] curr_value;
        logic [ADC_W-1:0] volt_mean;
        logic [ADC_W-1:0] curr_mean;
    } out_item_t;

    // Running sum and extremes of one channel
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [ADC_W-1:0] max_val;
        logic [ADC_W-1:0] min_val;
    } chan_acc_t;

    // One finished window, as queued for the back end
    typedef struct packed {
        chan_acc_t volt_acc;
        chan_acc_t curr_acc;
        chan_acc_t zero_acc;
    } window_t;

    typedef struct packed {
        logic [SCALE_W-1:0]       volt_scale;
        logic signed [BYTE_W-1:0] volt_offset;
        logic [SCALE_W-1:0]       curr_scale;
        logic [BYTE_W-1:0]        curr_deadband;
    } cfg_t;

endpackage

[sv/trimmed_mean_power_meter_core.sv]
// ============================================================================
// trimmed_mean_power_meter_core - trimmed-mean bus voltage and current meter
// Averages windows of ADC triples with the extremes removed and reports
// scaled voltage and current once per window.
// ============================================================================
// One sample triple is taken per clock cycle while in_ready is high; every
// SAMPLES-th item closes a window and yields one result item, all others
// yield none. A closed window is queued (two entries) for the back end,
// which loads the trimmed sums, divides them by SAMPLES-2 with a reciprocal
// multiplication, then forms the means, the multipliers and the output
// register in turn, the last once the previous result item has been taken,
// and only then takes the next window. Only the closing item of a window
// waits, and only while the window queue is full. Configuration writes take
// effect at once and belong in idle periods.
module trimmed_mean_power_meter_core #(
    parameter int SAMPLES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [tmpm_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tmpm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tmpm_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tmpm_pkg::out_item_t           out_data
);

    tmpm_pkg::cfg_t    cfg_reg;
    tmpm_pkg::window_t push_data;
    tmpm_pkg::window_t pop_data;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volt_scale    <= tmpm_pkg::VOLT_SCALE_RST;
            cfg_reg.volt_offset   <= tmpm_pkg::VOLT_OFFSET_RST;
            cfg_reg.curr_scale    <= tmpm_pkg::CURR_SCALE_RST;
            cfg_reg.curr_deadband <= tmpm_pkg::CURR_DEADBAND_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                tmpm_pkg::REG_VOLT_SCALE:
                    cfg_reg.volt_scale    <= cfg_data[tmpm_pkg::SCALE_W-1:0];
                tmpm_pkg::REG_VOLT_OFFSET:
                    cfg_reg.volt_offset   <= $signed(cfg_data[tmpm_pkg::BYTE_W-1:0]);
                tmpm_pkg::REG_CURR_SCALE:
                    cfg_reg.curr_scale    <= cfg_data[tmpm_pkg::SCALE_W-1:0];
                tmpm_pkg::REG_CURR_DEADBAND:
                    cfg_reg.curr_deadband <= cfg_data[tmpm_pkg::BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Accumulating front end
    tmpm_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Window queue
    tmpm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // Divide and scale back end
    tmpm_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[sv/tmpm_front.sv]
// ============================================================================
// tmpm_front - window accumulator
// Takes sample triples, keeps sum, maximum and minimum per channel and
// pushes the finished window into the result queue on its last item.
// ============================================================================
module tmpm_front #(
    parameter int SAMPLES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tmpm_pkg::in_item_t in_data,
    input  logic               q_full,
    output logic               push,
    output tmpm_pkg::window_t  push_data
);

    localparam tmpm_pkg::chan_acc_t ACC_CLEAR = '{
        sum:     '0,
        max_val: '0,
        min_val: tmpm_pkg::ADC_MAX
    };

    // Fold one sample into a channel
    function automatic tmpm_pkg::chan_acc_t track(
        input tmpm_pkg::chan_acc_t        acc,
        input logic [tmpm_pkg::ADC_W-1:0] s
    );
        tmpm_pkg::chan_acc_t r;
        r.sum     = acc.sum + tmpm_pkg::SUM_W'(s);
        r.max_val = (s > acc.max_val) ? s : acc.max_val;
        r.min_val = (s < acc.min_val) ? s : acc.min_val;
        return r;
    endfunction

    logic [tmpm_pkg::CNT_W-1:0] count_reg;
    tmpm_pkg::chan_acc_t        volt_acc_reg;
    tmpm_pkg::chan_acc_t        curr_acc_reg;
    tmpm_pkg::chan_acc_t        zero_acc_reg;

    tmpm_pkg::chan_acc_t volt_upd;
    tmpm_pkg::chan_acc_t curr_upd;
    tmpm_pkg::chan_acc_t zero_upd;
    logic                last_item;
    logic                accept;

    // Classify the item and decide whether it may enter
    always_comb
    begin
        volt_upd  = track(volt_acc_reg, in_data.volt_sample);
        curr_upd  = track(curr_acc_reg, in_data.curr_sample);
        zero_upd  = track(zero_acc_reg, in_data.ref_sample);
        last_item = (({1'b0, count_reg} + (tmpm_pkg::CNT_W + 1)'(1))
                     == (tmpm_pkg::CNT_W + 1)'(SAMPLES));
        // only the closing item of a window needs room in the queue
        in_ready  = !(last_item && q_full);
        accept    = in_valid && in_ready;
        push      = accept && last_item;
        push_data = '{volt_acc: volt_upd, curr_acc: curr_upd, zero_acc: zero_upd};
    end

    // Accumulators, cleared after each window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            volt_acc_reg <= ACC_CLEAR;
            curr_acc_reg <= ACC_CLEAR;
            zero_acc_reg <= ACC_CLEAR;
        end
        else if (accept)
        begin
            if (last_item)
            begin
                count_reg    <= '0;
                volt_acc_reg <= ACC_CLEAR;
                curr_acc_reg <= ACC_CLEAR;
                zero_acc_reg <= ACC_CLEAR;
            end
            else
            begin
                count_reg    <= count_reg + tmpm_pkg::CNT_W'(1);
                volt_acc_reg <= volt_upd;
                curr_acc_reg <= curr_upd;
                zero_acc_reg <= zero_upd;
            end
        end
    end

endmodule

[sv/tmpm_fifo.sv]
// ============================================================================
// tmpm_fifo - finished-window queue
// Short register queue that lets the accumulator and the arithmetic back
// end stall independently.
// ============================================================================
module tmpm_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tmpm_pkg::window_t push_data,
    output logic              full,
    input  logic              pop,
    output tmpm_pkg::window_t pop_data,
    output logic              empty
);

    tmpm_pkg::window_t           entry_reg [tmpm_pkg::QUEUE_DEPTH];
    logic [tmpm_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [tmpm_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [tmpm_pkg::QCNT_W-1:0] fill_reg;

    // Status
    assign full     = (fill_reg == tmpm_pkg::QCNT_W'(tmpm_pkg::QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tmpm_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tmpm_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + tmpm_pkg::QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - tmpm_pkg::QCNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/tmpm_back.sv]
// ============================================================================
// tmpm_back - trimmed mean and scaling engine
// Pops a finished window, divides the trimmed sums by a reciprocal
// multiplication, scales voltage and current and holds the result item.
// ============================================================================
module tmpm_back #(
    parameter int SAMPLES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tmpm_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  tmpm_pkg::window_t  q_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output tmpm_pkg::out_item_t out_data
);

    // Division by SAMPLES-2 as a multiply by a rounded-up reciprocal,
    // exact for every 18-bit dividend
    localparam int DIVISOR = SAMPLES - 2;
    localparam int RCP_SH  = tmpm_pkg::SUM_W + $clog2(DIVISOR);
    localparam int RCP_W   = tmpm_pkg::SUM_W + 1;
    localparam int QP_W    = tmpm_pkg::SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((1 << RCP_SH) + DIVISOR - 1) / DIVISOR);
    localparam int VQ_W = tmpm_pkg::PROD_W + 1 - tmpm_pkg::Q_FRAC;
    localparam int CQ_W = tmpm_pkg::PROD_W - tmpm_pkg::Q_FRAC;
    localparam int VS_W = VQ_W + 2;
    localparam logic [tmpm_pkg::PROD_W:0] ROUND_HALF =
        (tmpm_pkg::PROD_W + 1)'(1) << (tmpm_pkg::Q_FRAC - 1);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MEAN = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // Sum minus both extremes, floored at zero
    function automatic logic [tmpm_pkg::SUM_W-1:0] trim_rest(
        input tmpm_pkg::chan_acc_t a
    );
        logic [tmpm_pkg::SUM_W-1:0] cut;
        cut = tmpm_pkg::SUM_W'(a.max_val) + tmpm_pkg::SUM_W'(a.min_val);
        return (a.sum >= cut) ? (a.sum - cut) : '0;
    endfunction

    // Quotient clamped to the ADC range
    function automatic logic [tmpm_pkg::ADC_W-1:0] clamp_mean(
        input logic [tmpm_pkg::SUM_W-1:0] q
    );
        return (|q[tmpm_pkg::SUM_W-1:tmpm_pkg::ADC_W]) ? tmpm_pkg::ADC_MAX
                                                     : q[tmpm_pkg::ADC_W-1:0];
    endfunction

    logic [2:0]                     state_reg,  state_next;
    logic [tmpm_pkg::SUM_W-1:0]     dq_reg  [tmpm_pkg::CH_N];
    logic [tmpm_pkg::SUM_W-1:0]     dq_next [tmpm_pkg::CH_N];
    logic [tmpm_pkg::ADC_W-1:0]     vmean_reg, vmean_next;
    logic [tmpm_pkg::ADC_W-1:0]     cmean_reg, cmean_next;
    logic [tmpm_pkg::ADC_W-1:0]     diff_reg,  diff_next;
    logic [tmpm_pkg::PROD_W-1:0]    vprod_reg, vprod_next;
    logic [tmpm_pkg::PROD_W-1:0]    cprod_reg, cprod_next;
    logic                           out_valid_reg, out_valid_next;
    tmpm_pkg::out_item_t            out_data_reg,  out_data_next;

    logic [QP_W-1:0]                quot_prod [tmpm_pkg::CH_N];
    logic [tmpm_pkg::ADC_W-1:0]     zmean;
    logic [tmpm_pkg::PROD_W:0]      vround;
    logic [VQ_W-1:0]                vq;
    logic signed [VS_W-1:0]         vsum;
    logic [tmpm_pkg::VAL_W-1:0]     volt_val;
    logic [CQ_W-1:0]                cq;
    logic [CQ_W-1:0]                cq_db;
    logic [tmpm_pkg::VAL_W-1:0]     curr_val;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        dq_next        = dq_reg;
        vmean_next     = vmean_reg;
        cmean_next     = cmean_reg;
        diff_next      = diff_reg;
        vprod_next     = vprod_reg;
        cprod_next     = cprod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;

        // trimmed sum times reciprocal, one product per channel
        for (int i = 0; i < tmpm_pkg::CH_N; i++)
        begin
            quot_prod[i] = QP_W'(dq_reg[i]) * QP_W'(RECIP);
        end

        zmean = clamp_mean(dq_reg[2]);

        // final voltage: round, offset, clamp
        vround = {1'b0, vprod_reg} + ROUND_HALF;
        vq     = vround[tmpm_pkg::PROD_W:tmpm_pkg::Q_FRAC];
        vsum   = $signed({2'b00, vq}) + VS_W'(cfg.volt_offset);
        if (vsum < 0)
        begin
            volt_val = '0;
        end
        else if (vsum > $signed(VS_W'(tmpm_pkg::VAL_MAX)))
        begin
            volt_val = tmpm_pkg::VAL_MAX;
        end
        else
        begin
            volt_val = vsum[tmpm_pkg::VAL_W-1:0];
        end

        // final current: truncate, deadband, saturate
        cq    = cprod_reg[tmpm_pkg::PROD_W-1:tmpm_pkg::Q_FRAC];
        cq_db = (cq > CQ_W'(cfg.curr_deadband)) ? (cq - CQ_W'(cfg.curr_deadband)) : '0;
        curr_val = (|cq_db[CQ_W-1:tmpm_pkg::VAL_W]) ? tmpm_pkg::VAL_MAX
                                                    : cq_db[tmpm_pkg::VAL_W-1:0];

        // output register drains independently of the sequencer
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    dq_next[0] = trim_rest(q_data.volt_acc);
                    dq_next[1] = trim_rest(q_data.curr_acc);
                    dq_next[2] = trim_rest(q_data.zero_acc);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                for (int i = 0; i < tmpm_pkg::CH_N; i++)
                begin
                    dq_next[i] = tmpm_pkg::SUM_W'(quot_prod[i] >> RCP_SH);
                end
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                vmean_next = clamp_mean(dq_reg[0]);
                cmean_next = clamp_mean(dq_reg[1]);
                diff_next  = (cmean_next > zmean) ? (cmean_next - zmean)
                                                  : (zmean - cmean_next);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                vprod_next = tmpm_pkg::PROD_W'(vmean_reg) * tmpm_pkg::PROD_W'(cfg.volt_scale);
                cprod_next = tmpm_pkg::PROD_W'(diff_reg) * tmpm_pkg::PROD_W'(cfg.curr_scale);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{volt_value: volt_val, curr_value: curr_val,
                                       volt_mean: vmean_reg, curr_mean: cmean_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dq_reg       <= dq_next;
        vmean_reg    <= vmean_next;
        cmean_reg    <= cmean_next;
        diff_reg     <= diff_next;
        vprod_reg    <= vprod_next;
        cprod_reg    <= cprod_next;
        out_data_reg <= out_data_next;
    end

endmodule

[sv/tmpm_checker.sv]
// ============================================================================
// tmpm_checker - port-level checks of the power meter
// Tracks windows closed at the input against items delivered at the output.
// ============================================================================
module tmpm_checker #(
    parameter int SAMPLES = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input tmpm_pkg::out_item_t out_data
);

    localparam int CW = $clog2(SAMPLES);

    logic [CW-1:0] cnt_reg;
    logic [2:0]    pending_reg;
    logic          chk_last;
    logic          win_done;
    logic          out_take;

    assign chk_last = (cnt_reg == CW'(SAMPLES - 1));
    assign win_done = in_valid && in_ready && chk_last;
    assign out_take = out_valid && out_ready;

    // Item position in window and windows awaiting delivery
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cnt_reg <= chk_last ? '0 : cnt_reg + CW'(1);
            end
            if (win_done && !out_take)
            begin
                pending_reg <= pending_reg + 3'd1;
            end
            else if (out_take && !win_done)
            begin
                pending_reg <= pending_reg - 3'd1;
            end
        end
    end

    // A held result item stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // No result without a closed window
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result item without a completed window");

    // Input only stalls on the closing item of a window
    a_stall_at_close: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> chk_last)
        else $error("input stalled inside a window");

    // Queue, engine and output register hold at most four windows
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more windows in flight than storage allows");

endmodule

bind trimmed_mean_power_meter_core tmpm_checker #(
    .SAMPLES (SAMPLES)
) u_tmpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[test/tmpm_reading_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// tmpm_reading_checker - prediction and comparison for the power meter core
// Watches the register port and both item channels of the core. It keeps its
// own copy of the window accumulators and the registers. Each closing sample
// queues the expected reading, and each reading that leaves the core is
// compared field by field with the oldest one queued.
// ============================================================================
module tmpm_reading_checker #(
    parameter int SAMPLES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wen,
    input  logic [tmpm_pkg::IDX_W-1:0] cfg_index,
    input  logic [tmpm_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  tmpm_pkg::in_item_t         in_data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  tmpm_pkg::out_item_t        out_data,
    output int                         fault_count,
    output int                         readings_due
);
    import tmpm_pkg::*;

    // Running sum and extremes of one ADC channel
    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [ADC_W-1:0] peak;
        logic [ADC_W-1:0] trough;
    } channel_track_t;

    channel_track_t volt_trk;
    channel_track_t curr_trk;
    channel_track_t zero_trk;
    int             fill;
    cfg_t           meter_cfg;
    out_item_t      pending_readings[$];
    int             faults;

    function automatic channel_track_t add_sample(channel_track_t t, logic [ADC_W-1:0] s);
        channel_track_t n;
        n = t;
        n.total = t.total + SUM_W'(s);
        if (s > t.peak)
            n.peak = s;
        if (s < t.trough)
            n.trough = s;
        return n;
    endfunction

    // Sum less both extremes, over the samples that remain
    function automatic logic [ADC_W-1:0] trimmed_mean(channel_track_t t);
        int unsigned cut;
        int unsigned rest;
        int unsigned m;
        cut  = t.peak + t.trough;
        rest = (t.total >= cut) ? t.total - cut : 0;
        m    = rest / (SAMPLES - 2);
        return (m > ADC_MAX) ? ADC_MAX : m[ADC_W-1:0];
    endfunction

    // Scaled voltage and current of the window just closed
    function automatic out_item_t meter_reading();
        logic [ADC_W-1:0] vm;
        logic [ADC_W-1:0] cm;
        logic [ADC_W-1:0] zm;
        logic [ADC_W-1:0] diff;
        longint           vv;
        longint           cq;
        out_item_t        r;
        vm = trimmed_mean(volt_trk);
        cm = trimmed_mean(curr_trk);
        zm = trimmed_mean(zero_trk);

        // voltage: Q16 with rounding, signed offset, clamp both ways
        vv = (longint'(vm) * longint'(meter_cfg.volt_scale) + 32768) >> Q_FRAC;
        vv = vv + longint'(meter_cfg.volt_offset);
        if (vv < 0)
            vv = 0;
        else if (vv > longint'(VAL_MAX))
            vv = longint'(VAL_MAX);

        // current: truncated Q16, deadband floored at zero, saturate
        diff = (cm > zm) ? cm - zm : zm - cm;
        cq = (longint'(diff) * longint'(meter_cfg.curr_scale)) >> Q_FRAC;
        cq = (cq > longint'(meter_cfg.curr_deadband)) ?
             cq - longint'(meter_cfg.curr_deadband) : 0;
        if (cq > longint'(VAL_MAX))
            cq = longint'(VAL_MAX);

        r.volt_value = vv[VAL_W-1:0];
        r.curr_value = cq[VAL_W-1:0];
        r.volt_mean  = vm;
        r.curr_mean  = cm;
        return r;
    endfunction

    task automatic start_window();
        volt_trk = '{total: '0, peak: '0, trough: ADC_MAX};
        curr_trk = volt_trk;
        zero_trk = volt_trk;
        fill     = 0;
    endtask

    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            faults++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            start_window();
            meter_cfg.volt_scale    = VOLT_SCALE_RST;
            meter_cfg.volt_offset   = VOLT_OFFSET_RST;
            meter_cfg.curr_scale    = CURR_SCALE_RST;
            meter_cfg.curr_deadband = CURR_DEADBAND_RST;
            pending_readings.delete();
            faults = 0;
            fault_count  <= 0;
            readings_due <= 0;
        end
        else
        begin
            // readings leaving the core
            if (out_valid && out_ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    $display("%0t ns: unexpected reading, expected none, actual %0d/%0d/%0d/%0d",
                             $time, out_data.volt_value, out_data.curr_value,
                             out_data.volt_mean, out_data.curr_mean);
                    faults++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    compare_field("volt_value", want.volt_value, out_data.volt_value);
                    compare_field("curr_value", want.curr_value, out_data.curr_value);
                    compare_field("volt_mean", want.volt_mean, out_data.volt_mean);
                    compare_field("curr_mean", want.curr_mean, out_data.curr_mean);
                end
            end

            // sample triples entering; the last of a window queues a reading
            if (in_valid && in_ready)
            begin
                volt_trk = add_sample(volt_trk, in_data.volt_sample);
                curr_trk = add_sample(curr_trk, in_data.curr_sample);
                zero_trk = add_sample(zero_trk, in_data.ref_sample);
                fill++;
                if (fill == SAMPLES)
                begin
                    pending_readings.push_back(meter_reading());
                    start_window();
                end
            end

            // register writes, only the register's own width is kept
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_VOLT_SCALE:    meter_cfg.volt_scale    = cfg_data[SCALE_W-1:0];
                    REG_VOLT_OFFSET:   meter_cfg.volt_offset   = cfg_data[BYTE_W-1:0];
                    REG_CURR_SCALE:    meter_cfg.curr_scale    = cfg_data[SCALE_W-1:0];
                    REG_CURR_DEADBAND: meter_cfg.curr_deadband = cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end

            fault_count  <= faults;
            readings_due <= pending_readings.size();
        end
    end

endmodule

[test/trimmed_mean_power_meter_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// trimmed_mean_power_meter_core_tb - stimulus for the power meter core
// Feeds windows of ADC sample triples in several register settings, the
// extremes among them, with random gaps on the sample side and random stalls
// on the reading side. The checker beside the core predicts every reading.
// ============================================================================
module trimmed_mean_power_meter_core_tb;
    import tmpm_pkg::*;

    localparam int SAMPLES      = 16;
    localparam int ITEM_TARGET  = 1650;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_ROUND   = 25;

    typedef enum int {
        STYLE_NOISE,
        STYLE_FLAT,
        STYLE_RAILS,
        STYLE_TRACE
    } window_style_e;

    logic             clk;
    logic             rst_n;
    logic             cfg_wen;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_data;
    int               fault_count;
    int               readings_due;

    trimmed_mean_power_meter_core #(
        .SAMPLES (SAMPLES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    tmpm_reading_checker #(
        .SAMPLES (SAMPLES)
    ) reading_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .fault_count  (fault_count),
        .readings_due (readings_due)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run limit, far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Gap before a sample item: mostly none, a few long
    function automatic int sender_gap(bit burst);
        int roll;
        roll = $urandom_range(99);
        if (burst || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        if (roll < 98)
            return $urandom_range(15, 4);
        return $urandom_range(80, 30);
    endfunction

    function automatic int ready_span();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return $urandom_range(8, 1);
        return $urandom_range(150, 50);
    endfunction

    function automatic int receiver_stall();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return $urandom_range(2, 1);
        if (roll < 92)
            return $urandom_range(6, 3);
        return $urandom_range(60, 20);
    endfunction

    // Random value around a centre, held inside the ADC range
    function automatic logic [ADC_W-1:0] near(int centre, int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > int'(ADC_MAX))
            v = int'(ADC_MAX);
        return v[ADC_W-1:0];
    endfunction

    function automatic logic [ADC_W-1:0] rail_or(logic [ADC_W-1:0] centre);
        case ($urandom_range(2))
            0: return '0;
            1: return ADC_MAX;
            default: return centre;
        endcase
    endfunction

    // 8-bit register value with random junk above it
    function automatic logic [CFG_W-1:0] byte_word(logic [BYTE_W-1:0] b);
        return CFG_W'({$urandom_range(65535), b});
    endfunction

    task automatic push_sample(in_item_t s, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Wait for every reading owed, then for the back end to go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(int phase);
        case (phase)
            1:
            begin
                // everything saturates high
                write_reg(REG_VOLT_SCALE, '1);
                write_reg(REG_VOLT_OFFSET, byte_word(8'h7F));
                write_reg(REG_CURR_SCALE, '1);
                write_reg(REG_CURR_DEADBAND, byte_word(8'h00));
            end
            2:
            begin
                // zero scales, most negative offset, widest deadband
                write_reg(REG_VOLT_SCALE, '0);
                write_reg(REG_VOLT_OFFSET, byte_word(8'h80));
                write_reg(REG_CURR_SCALE, '0);
                write_reg(REG_CURR_DEADBAND, byte_word(8'hFF));
            end
            3:
            begin
                write_reg(REG_CURR_DEADBAND, CFG_W'($urandom));
                write_reg(REG_CURR_SCALE, CFG_W'($urandom));
                write_reg(REG_VOLT_OFFSET, CFG_W'($urandom));
                write_reg(REG_VOLT_SCALE, CFG_W'($urandom));
            end
            4:
            begin
                // scales in a range that keeps most readings unclamped
                write_reg(REG_VOLT_SCALE, CFG_W'($urandom_range(200000)));
                write_reg(REG_VOLT_OFFSET, CFG_W'($urandom));
                write_reg(REG_CURR_SCALE, CFG_W'($urandom_range(400000)));
                write_reg(REG_CURR_DEADBAND, CFG_W'($urandom_range(40)));
            end
            default:
            begin
                write_reg(REG_VOLT_SCALE, VOLT_SCALE_RST);
                write_reg(REG_VOLT_OFFSET, byte_word(VOLT_OFFSET_RST));
                write_reg(REG_CURR_SCALE, CURR_SCALE_RST);
                write_reg(REG_CURR_DEADBAND, byte_word(CURR_DEADBAND_RST));
            end
        endcase
        cfg_wen <= 1'b0;
    endtask

    // One run of samples in a random style
    task automatic feed_window(int count, bit burst);
        window_style_e style;
        int            vc;
        int            cc;
        int            zc;
        int            k;
        in_item_t      s;
        style = window_style_e'($urandom_range(STYLE_TRACE));
        vc = $urandom_range(ADC_MAX);
        zc = (style == STYLE_TRACE) ? $urandom_range(2348, 1748) : $urandom_range(ADC_MAX);
        cc = (style == STYLE_TRACE) ? zc + int'($urandom_range(1200)) - 600
                                    : $urandom_range(ADC_MAX);
        for (k = 0; k < count; k++)
        begin
            case (style)
                STYLE_FLAT:
                    s = '{volt_sample: ADC_W'(vc), curr_sample: ADC_W'(cc),
                          ref_sample: ADC_W'(zc)};
                STYLE_RAILS:
                    s = '{volt_sample: rail_or(ADC_W'(vc)), curr_sample: rail_or(ADC_W'(cc)),
                          ref_sample: rail_or(ADC_W'(zc))};
                STYLE_TRACE:
                begin
                    s = '{volt_sample: near(vc, 8), curr_sample: near(cc, 12),
                          ref_sample: near(zc, 4)};
                    // occasional spike, which the trim should remove
                    if ($urandom_range(15) == 0)
                        s.curr_sample = ADC_W'($urandom_range(ADC_MAX));
                end
                default:
                    s = '{volt_sample: ADC_W'($urandom_range(ADC_MAX)),
                          curr_sample: ADC_W'($urandom_range(ADC_MAX)),
                          ref_sample: ADC_W'($urandom_range(ADC_MAX))};
            endcase
            push_sample(s, sender_gap(burst));
        end
    endtask

    // Reading side: random ready and stall stretches, one long hold-off
    initial
    begin : reading_sink
        int rounds;
        out_ready <= 1'b0;
        rounds = 0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat (ready_span()) @(posedge clk);
            out_ready <= 1'b0;
            rounds++;
            if (rounds == HOLD_ROUND)
                repeat (HOLD_CYCLES) @(posedge clk);
            else
                repeat (receiver_stall()) @(posedge clk);
        end
    end

    // Sample side and verdict
    initial
    begin : sample_source
        int       phase;
        int       w;
        int       k;
        int       windows_per_phase;
        in_item_t rails;
        rst_n     <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all samples equal, at the rails, widest current difference
        rails = '{volt_sample: ADC_MAX, curr_sample: '0, ref_sample: ADC_MAX};
        for (k = 0; k < SAMPLES; k++)
            push_sample(rails, 0);

        windows_per_phase = (ITEM_TARGET - SAMPLES) / (SAMPLES * PHASES);
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                load_setting(phase);
            end
            for (w = 0; w < windows_per_phase; w++)
                feed_window(SAMPLES, $urandom_range(4) == 0);
            // leave a part window open across the register change
            feed_window($urandom_range(SAMPLES - 1), 1'b0);
        end

        settle();
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
sv/tmpm_pkg.sv
sv/tmpm_front.sv
sv/tmpm_fifo.sv
sv/tmpm_back.sv
sv/trimmed_mean_power_meter_core.sv
sv/tmpm_checker.sv
test/tmpm_reading_checker.sv
test/trimmed_mean_power_meter_core_tb.sv
